/* rtl/md5he_pkg.sv */
`default_nettype none

package md5he_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_OUT0,
        S_OUT1
    } md5he_state_t;

    // controller -> datapath
    typedef struct packed {
        logic push_in;     // store the accepted message byte
        logic set_pad;     // end of message seen, padding follows
        logic push_pad;    // store one padding or length byte
        logic round_step;  // run one compression round
        logic chain_add;   // fold working words into chaining words
        logic msg_clear;   // back to initial state after digest output
        logic half_sel;    // which digest half is shown
    } md5he_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_last;   // next byte completes the block
        logic round_last;  // current round is round 63
        logic pad_active;  // message closed, padding in progress
        logic pad_done;    // last length byte stored
    } md5he_sts_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

/* rtl/md5he_dp.sv */
`default_nettype none

module md5he_dp (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire [7:0]              data_byte,
    input  wire md5he_pkg::md5he_cmd_t cmd,
    output md5he_pkg::md5he_sts_t  sts,
    output logic [63:0]            digest_half
);
    import md5he_pkg::*;

    logic [31:0] word_mem [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] w_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic        pad_active_reg;
    logic        marker_done_reg;
    logic        len_phase_reg;
    logic [2:0]  len_idx_reg;
    logic        pad_done_reg;

    logic        push_en;
    logic        block_full;
    logic        len_byte_sel;
    logic [7:0]  pad_byte;
    logic [7:0]  push_byte;

    logic [5:0]  rd_round;
    logic [31:0] f_val;
    logic [31:0] w_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] rot_val;

    // message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] idx;
        unique case (r[5:4])
            2'd0:    idx = r[3:0];
            2'd1:    idx = 4'(r[3:0] * 4'd5 + 4'd1);
            2'd2:    idx = 4'(r[3:0] * 4'd3 + 4'd5);
            default: idx = 4'(r[3:0] * 4'd7);
        endcase
        return idx;
    endfunction

    assign push_en    = cmd.push_in | cmd.push_pad;
    assign block_full = push_en && (fill_reg == 6'd63);

    // length bytes start once the fill reaches the length field
    assign len_byte_sel = len_phase_reg || (fill_reg == LEN_START);

    always_comb
    begin
        if (!marker_done_reg)
            pad_byte = PAD_MARKER;
        else if (len_byte_sel)
            pad_byte = len_reg[{len_idx_reg, 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    assign push_byte = cmd.push_pad ? pad_byte : data_byte;

    // word for the coming round is registered into w_reg in the cycle before it
    assign rd_round = block_full ? 6'd0 : round_reg + 6'd1;

    always_ff @(posedge clk)
    begin
        if (push_en)
            word_mem[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= push_byte;
        if (block_full || cmd.round_step)
            w_reg <= word_mem[msg_index(rd_round)];
    end

    // round function
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign w_val    = w_reg;
    assign sum      = a_reg + f_val + ROUND_K[round_reg] + w_val;
    assign rot_wide = {sum, sum} << ROT_S[{round_reg[5:4], round_reg[1:0]}];
    assign rot_val  = rot_wide[63:32];

    always_ff @(posedge clk)
    begin
        if (block_full)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.round_step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= CHAIN_INIT[i];
            fill_reg        <= '0;
            len_reg         <= '0;
            round_reg       <= '0;
            pad_active_reg  <= 1'b0;
            marker_done_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
            len_idx_reg     <= '0;
            pad_done_reg    <= 1'b0;
        end
        else if (cmd.msg_clear)
        begin
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= CHAIN_INIT[i];
            fill_reg        <= '0;
            len_reg         <= '0;
            round_reg       <= '0;
            pad_active_reg  <= 1'b0;
            marker_done_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
            len_idx_reg     <= '0;
            pad_done_reg    <= 1'b0;
        end
        else
        begin
            if (push_en)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.push_in)
                len_reg <= len_reg + 64'd8;
            if (cmd.set_pad)
                pad_active_reg <= 1'b1;
            if (cmd.push_pad)
            begin
                if (!marker_done_reg)
                    marker_done_reg <= 1'b1;
                else if (len_byte_sel)
                begin
                    len_phase_reg <= 1'b1;
                    len_idx_reg   <= len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                        pad_done_reg <= 1'b1;
                end
            end
            if (block_full)
                round_reg <= '0;
            else if (cmd.round_step)
                round_reg <= round_reg + 6'd1;
            if (cmd.chain_add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    assign sts.fill_last  = (fill_reg == 6'd63);
    assign sts.round_last = (round_reg == 6'd63);
    assign sts.pad_active = pad_active_reg;
    assign sts.pad_done   = pad_done_reg;

    assign digest_half = cmd.half_sel
                       ? {bswap32(chain_reg[2]), bswap32(chain_reg[3])}
                       : {bswap32(chain_reg[0]), bswap32(chain_reg[1])};

endmodule

`default_nettype wire

/* rtl/md5he_ctrl.sv */
`default_nettype none

module md5he_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    byte_present,
    input  wire                    end_of_message,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   half_index,
    output logic                   digest_done,
    output md5he_pkg::md5he_cmd_t  cmd,
    input  wire md5he_pkg::md5he_sts_t sts
);
    import md5he_pkg::*;

    md5he_state_t state_reg;
    md5he_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.push_in = byte_present;
                    cmd.set_pad = end_of_message;
                    if (byte_present && sts.fill_last)
                        state_next = S_ROUND;
                    else if (end_of_message)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.push_pad = 1'b1;
                if (sts.fill_last)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (sts.round_last)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.chain_add = 1'b1;
                if (sts.pad_done)
                    state_next = S_OUT0;
                else if (sts.pad_active)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_OUT0:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_OUT1;
            end
            S_OUT1:
            begin
                out_valid    = 1'b1;
                cmd.half_sel = 1'b1;
                if (out_ready)
                begin
                    cmd.msg_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign half_index  = cmd.half_sel;
    assign digest_done = cmd.half_sel;

    // the digest only goes out after the block holding the length is folded in
    a_out_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT0 && $past(state_reg) != S_OUT0) |->
            $past(state_reg) == S_FINAL)
        else $error("digest shown without final chain add");

    a_round_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && sts.round_last) |=> state_reg == S_FINAL)
        else $error("compression did not end after round 63");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT1 && out_ready) |=>
            (state_reg == S_IDLE && !sts.pad_active && !sts.pad_done))
        else $error("message state not cleared after digest");

    a_pad_needs_eom: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pad_done |-> sts.pad_active)
        else $error("length stored without end of message");

endmodule

`default_nettype wire

/* rtl/md5_hash_engine_top.sv */
`default_nettype none

// channel | signals                                       | dir
// in      | in_valid, in_ready, data_byte, byte_present,  | request in
//         | end_of_message                                |
// out     | out_valid, out_ready, digest_half,            | request out
//         | half_index, digest_done                       |
//
// A byte that does not close a 64-byte block leaves in_ready high.
// A closing byte starts 64 rounds, one per cycle, then one chain add, with in_ready low.
// End of message: padding and length bytes are stored one per cycle (9 to 72),
// with one or two block compressions, then two digest requests are offered.
// in_ready is low while padding, compressing or presenting the digest.
// Reset (rst_n low, asynchronous) loads the initial chaining words; no clearing pass.

module md5_hash_engine_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [7:0]   data_byte,
    input  wire         byte_present,
    input  wire         end_of_message,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [63:0] digest_half,
    output logic        half_index,
    output logic        digest_done
);
    import md5he_pkg::*;

    md5he_cmd_t cmd;
    md5he_sts_t sts;

    md5he_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .half_index     (half_index),
        .digest_done    (digest_done),
        .cmd            (cmd),
        .sts            (sts)
    );

    md5he_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .sts         (sts),
        .digest_half (digest_half)
    );

endmodule

`default_nettype wire
